>>> rtl/gtsa_pkg.sv
// Shared types and constants for the generation-tagged slot allocator.
// Holds slot and count widths, command and register codes, and the
// request and status structs that pass between the allocator's modules.
`default_nettype none

package gtsa_pkg;

	// Pool geometry; slot fields are 6 bits wide
	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int GEN_W     = 32;
	localparam int CFG_W     = 7;

	// Flush reporting limits
	localparam int MAX_RUNS  = 32;
	localparam int RUN_LIMIT = 64;
	localparam int RUNS_W    = $clog2(MAX_RUNS + 1);

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_FLUSH   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_SLOTS_IN_USE     = 1'b0,
		REG_DIRTY_ON_RELEASE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		STK_CLEAN = 1'b0,
		STK_DIRTY = 1'b1
	} stk_sel_t;

	// Pool restart: taken on every configuration write
	typedef struct packed {
		logic             restart;
		logic             dirty;
		logic [CNT_W-1:0] slots;
	} pool_cfg_t;

	// One stack operation per cycle
	typedef struct packed {
		logic              pop;
		logic              push;
		logic              clear_dirty;
		stk_sel_t          sel;
		logic [SLOT_W-1:0] slot;
	} stk_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] clean_count;
		logic [CNT_W-1:0] dirty_count;
	} stk_stat_t;

	// Generation store access
	typedef struct packed {
		logic              rd;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr;
		logic [SLOT_W-1:0] wr_addr;
		logic [GEN_W-1:0]  wr_data;
	} gen_req_t;

endpackage

`default_nettype wire

>>> rtl/generation_tagged_slot_allocator.sv
// Generation-tagged slot allocator. Hands out slots 0..n-1 from a clean and a
// dirty LIFO stack; each slot carries a 32-bit generation bumped on every
// acquire and accepted release, so stale handles are rejected. One transaction
// is worked at a time. Acquire reads the stack RAM, then does a read-modify-write
// of the generation RAM; release reads the generation RAM, then compares and
// writes back; a failed acquire or unknown command gives a zero result. Flush
// walks the 64 dirty marks one slot per cycle, holding while a closed run
// cannot be delivered. When a 33rd run would begin, the walk stops at that
// slot and a descending pass rebuilds the dirty stack from the leftovers.
// Every result also waits on the output register. A configuration write
// restarts the pool; tags clear via valid bits, stacks via low-water marks.
// Depends on gtsa_pkg, gtsa_stack and gtsa_gen_store.
`default_nettype none

module generation_tagged_slot_allocator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port
	input  wire logic                           cfg_wr_en,
	input  wire logic                           cfg_index,
	input  wire logic [gtsa_pkg::CFG_W-1:0]     cfg_data,
	// Command channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     command,
	input  wire logic [gtsa_pkg::SLOT_W-1:0]    slot_index,
	input  wire logic [gtsa_pkg::GEN_W-1:0]     generation,
	// Result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                granted,
	output logic [gtsa_pkg::SLOT_W-1:0]         out_slot,
	output logic [gtsa_pkg::GEN_W-1:0]          out_generation,
	output logic [gtsa_pkg::SLOT_W-1:0]         run_base,
	output logic [gtsa_pkg::CNT_W-1:0]          run_length,
	output logic                                last
);

	import gtsa_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE       = 8'b0000_0001,
		ST_ACQ_POP    = 8'b0000_0010,
		ST_ACQ_GEN    = 8'b0000_0100,
		ST_REL_CHK    = 8'b0000_1000,
		ST_FL_WALK    = 8'b0001_0000,
		ST_FL_END     = 8'b0010_0000,
		ST_FL_REBUILD = 8'b0100_0000,
		ST_RESP_ZERO  = 8'b1000_0000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     pool_q;
	logic                 dirty_mode_q;
	logic [NUM_SLOTS-1:0] marks_q;
	logic [NUM_SLOTS-1:0] restart_marks;
	logic [CNT_W-1:0]     new_n;
	logic                 new_dirty;
	logic [CNT_W-1:0]     clamp_n;
	pool_cfg_t            pool_cfg;

	// Per-transaction registers
	logic [SLOT_W-1:0]    slot_q, slot_d;
	logic [GEN_W-1:0]     gen_q, gen_d;
	logic                 in_range_q, in_range_d;
	logic [SLOT_W-1:0]    scan_q, scan_d;
	logic [SLOT_W-1:0]    run_start_q, run_start_d;
	logic [CNT_W-1:0]     run_count_q, run_count_d;
	logic [RUNS_W-1:0]    runs_q, runs_d;

	// Output register
	logic                 out_valid_q;
	logic                 granted_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic [GEN_W-1:0]     out_gen_q;
	logic [SLOT_W-1:0]    run_base_q;
	logic [CNT_W-1:0]     run_length_q;
	logic                 last_q;
	logic                 out_free;
	logic                 out_load;
	logic                 o_granted;
	logic [SLOT_W-1:0]    o_slot;
	logic [GEN_W-1:0]     o_gen;
	logic [SLOT_W-1:0]    o_start;
	logic [CNT_W-1:0]     o_count;
	logic                 o_last;

	// Submodule interfaces
	stk_req_t             stk_req;
	stk_stat_t            stk_stat;
	logic [SLOT_W-1:0]    stk_rd_slot;
	gen_req_t             gen_req;
	logic [GEN_W-1:0]     gen_rd;

	// Dirty mark updates
	logic                 mark_set;
	logic                 mark_clr;
	logic [SLOT_W-1:0]    mark_idx;

	// Flush walk decode
	logic                 in_acc;
	logic                 walk_mark;
	logic                 walk_extend;
	logic                 walk_close;
	logic                 walk_break;
	logic                 last_scan;
	logic                 rel_ok;
	logic [GEN_W-1:0]     gen_inc;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign walk_mark   = marks_q[scan_q];
	assign walk_extend = (run_count_q != '0)
		&& ({1'b0, scan_q} == ({1'b0, run_start_q} + run_count_q))
		&& (run_count_q < CNT_W'(RUN_LIMIT));
	assign walk_close  = walk_mark && !walk_extend && (run_count_q != '0);
	assign walk_break  = walk_close && (runs_q == RUNS_W'(MAX_RUNS - 1));
	assign last_scan   = (scan_q == SLOT_W'(NUM_SLOTS - 1));
	assign rel_ok      = in_range_q && (gen_rd == gen_q);
	assign gen_inc     = gen_rd + GEN_W'(1);

	// Clamp the slot count register to 1..NUM_SLOTS
	always_comb begin
		priority if (cfg_data == '0) begin
			clamp_n = CNT_W'(1);
		end else if (CNT_W'(cfg_data) > CNT_W'(NUM_SLOTS)) begin
			clamp_n = CNT_W'(NUM_SLOTS);
		end else begin
			clamp_n = CNT_W'(cfg_data);
		end
	end

	// Build the restarted pool settings
	always_comb begin
		new_n     = pool_q;
		new_dirty = dirty_mode_q;
		unique case (cfg_reg_t'(cfg_index))
			REG_SLOTS_IN_USE:     new_n     = clamp_n;
			REG_DIRTY_ON_RELEASE: new_dirty = cfg_data[0];
			default:              new_n     = pool_q;
		endcase
		for (int i = 0; i < NUM_SLOTS; i++) begin
			restart_marks[i] = new_dirty && (CNT_W'(i) < new_n);
		end
	end

	assign pool_cfg.restart = cfg_wr_en;
	assign pool_cfg.dirty   = new_dirty;
	assign pool_cfg.slots   = new_n;

	gtsa_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (pool_cfg),
		.req    (stk_req),
		.stat   (stk_stat),
		.rd_slot(stk_rd_slot)
	);

	gtsa_gen_store u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_wr_en),
		.req    (gen_req),
		.rd_gen (gen_rd)
	);

	// Sequencer: next state, memory requests and result loading
	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		gen_d       = gen_q;
		in_range_d  = in_range_q;
		scan_d      = scan_q;
		run_start_d = run_start_q;
		run_count_d = run_count_q;
		runs_d      = runs_q;
		stk_req     = '0;
		gen_req     = '0;
		mark_set    = 1'b0;
		mark_clr    = 1'b0;
		mark_idx    = slot_q;
		out_load    = 1'b0;
		o_granted   = 1'b0;
		o_slot      = '0;
		o_gen       = '0;
		o_start     = '0;
		o_count     = '0;
		o_last      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd_t'(command))
						CMD_ACQUIRE: begin
							// Pop clean first, then dirty
							priority if (stk_stat.clean_count != '0) begin
								stk_req.pop = 1'b1;
								stk_req.sel = STK_CLEAN;
								state_d     = ST_ACQ_POP;
							end else if (stk_stat.dirty_count != '0) begin
								stk_req.pop = 1'b1;
								stk_req.sel = STK_DIRTY;
								state_d     = ST_ACQ_POP;
							end else begin
								state_d = ST_RESP_ZERO;
							end
						end
						CMD_RELEASE: begin
							gen_req.rd      = 1'b1;
							gen_req.rd_addr = slot_index;
							slot_d          = slot_index;
							gen_d           = generation;
							in_range_d      = ({1'b0, slot_index} < pool_q);
							state_d         = ST_REL_CHK;
						end
						CMD_FLUSH: begin
							scan_d      = '0;
							run_start_d = '0;
							run_count_d = '0;
							runs_d      = '0;
							state_d     = ST_FL_WALK;
						end
						CMD_NONE: begin
							state_d = ST_RESP_ZERO;
						end
						default: begin
							state_d = ST_RESP_ZERO;
						end
					endcase
				end
			end

			ST_ACQ_POP: begin
				// Slot known: fetch its tag and drop its dirty mark
				gen_req.rd      = 1'b1;
				gen_req.rd_addr = stk_rd_slot;
				slot_d          = stk_rd_slot;
				mark_clr        = 1'b1;
				mark_idx        = stk_rd_slot;
				state_d         = ST_ACQ_GEN;
			end

			ST_ACQ_GEN: begin
				if (out_free) begin
					gen_req.wr      = 1'b1;
					gen_req.wr_addr = slot_q;
					gen_req.wr_data = gen_inc;
					out_load        = 1'b1;
					o_granted       = 1'b1;
					o_slot          = slot_q;
					o_gen           = gen_inc;
					o_last          = 1'b1;
					state_d         = ST_IDLE;
				end
			end

			ST_REL_CHK: begin
				if (out_free) begin
					out_load  = 1'b1;
					o_granted = rel_ok;
					o_last    = 1'b1;
					if (rel_ok) begin
						gen_req.wr      = 1'b1;
						gen_req.wr_addr = slot_q;
						gen_req.wr_data = gen_inc;
						stk_req.slot    = slot_q;
						if (dirty_mode_q) begin
							// Push once; an already dirty slot stays where it is
							if (!marks_q[slot_q]) begin
								mark_set     = 1'b1;
								mark_idx     = slot_q;
								stk_req.push = 1'b1;
								stk_req.sel  = STK_DIRTY;
							end
						end else begin
							stk_req.push = 1'b1;
							stk_req.sel  = STK_CLEAN;
						end
					end
					state_d = ST_IDLE;
				end
			end

			ST_FL_WALK: begin
				// Hold the walk while a closed run cannot be delivered
				if (!(walk_close && !out_free)) begin
					if (walk_close) begin
						out_load    = 1'b1;
						o_granted   = 1'b1;
						o_start     = run_start_q;
						o_count     = run_count_q;
						o_last      = walk_break;
						runs_d      = runs_q + RUNS_W'(1);
						run_count_d = '0;
					end
					if (walk_mark && walk_extend) begin
						run_count_d  = run_count_q + CNT_W'(1);
						mark_clr     = 1'b1;
						mark_idx     = scan_q;
						stk_req.push = 1'b1;
						stk_req.sel  = STK_CLEAN;
						stk_req.slot = scan_q;
					end else if (walk_mark && !walk_break) begin
						run_start_d  = scan_q;
						run_count_d  = CNT_W'(1);
						mark_clr     = 1'b1;
						mark_idx     = scan_q;
						stk_req.push = 1'b1;
						stk_req.sel  = STK_CLEAN;
						stk_req.slot = scan_q;
					end
					priority if (walk_break) begin
						// Run limit hit: rebuild the dirty stack from the leftovers
						stk_req.clear_dirty = 1'b1;
						scan_d              = SLOT_W'(NUM_SLOTS - 1);
						state_d             = ST_FL_REBUILD;
					end else if (last_scan) begin
						state_d = ST_FL_END;
					end else begin
						scan_d = scan_q + SLOT_W'(1);
					end
				end
			end

			ST_FL_END: begin
				if (out_free) begin
					out_load            = 1'b1;
					o_granted           = 1'b1;
					o_start             = (run_count_q != '0) ? run_start_q : '0;
					o_count             = run_count_q;
					o_last              = 1'b1;
					stk_req.clear_dirty = 1'b1;
					state_d             = ST_IDLE;
				end
			end

			ST_FL_REBUILD: begin
				// Descend so the lowest leftover slot ends on top
				if (marks_q[scan_q]) begin
					stk_req.push = 1'b1;
					stk_req.sel  = STK_DIRTY;
					stk_req.slot = scan_q;
				end
				if (scan_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					scan_d = scan_q - SLOT_W'(1);
				end
			end

			ST_RESP_ZERO: begin
				if (out_free) begin
					out_load = 1'b1;
					o_last   = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state, pool settings and dirty marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_q       <= CNT_W'(NUM_SLOTS);
			dirty_mode_q <= 1'b1;
			marks_q      <= '1;
			scan_q       <= '0;
			run_start_q  <= '0;
			run_count_q  <= '0;
			runs_q       <= '0;
		end else begin
			state_q     <= state_d;
			scan_q      <= scan_d;
			run_start_q <= run_start_d;
			run_count_q <= run_count_d;
			runs_q      <= runs_d;
			if (cfg_wr_en) begin
				pool_q       <= new_n;
				dirty_mode_q <= new_dirty;
				marks_q      <= restart_marks;
			end else if (mark_set) begin
				marks_q[mark_idx] <= 1'b1;
			end else if (mark_clr) begin
				marks_q[mark_idx] <= 1'b0;
			end
		end
	end

	// Transaction payload
	always_ff @(posedge clk) begin
		slot_q     <= slot_d;
		gen_q      <= gen_d;
		in_range_q <= in_range_d;
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			granted_q    <= o_granted;
			out_slot_q   <= o_slot;
			out_gen_q    <= o_gen;
			run_base_q   <= o_start;
			run_length_q <= o_count;
			last_q       <= o_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign out_slot       = out_slot_q;
	assign out_generation = out_gen_q;
	assign run_base       = run_base_q;
	assign run_length     = run_length_q;
	assign last           = last_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_stat.clean_count <= CNT_W'(NUM_SLOTS))
		&& (stk_stat.dirty_count <= CNT_W'(NUM_SLOTS)))
		else $error("stack count above pool capacity");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while held");

	a_flush_empties_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_END && out_free && !cfg_wr_en) |=> (stk_stat.dirty_count == '0))
		else $error("dirty stack not emptied by flush");

	a_acquire_clears_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACQ_POP && !cfg_wr_en) |=> !marks_q[slot_q])
		else $error("acquired slot still marked dirty");

endmodule

`default_nettype wire

>>> rtl/gtsa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds until the next read. No dependencies.
`default_nettype none

module gtsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

>>> rtl/gtsa_stack.sv
// Clean and dirty LIFO stacks sharing one RAM, with counts and low-water marks.
// Entries below the low-water mark still hold their restart value.
// Depends on gtsa_pkg and gtsa_ram.
`default_nettype none

module gtsa_stack (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire gtsa_pkg::pool_cfg_t       cfg,
	input  wire gtsa_pkg::stk_req_t        req,
	output gtsa_pkg::stk_stat_t            stat,
	output logic [gtsa_pkg::SLOT_W-1:0]    rd_slot
);

	import gtsa_pkg::*;

	logic [CNT_W-1:0]  clean_cnt_q;
	logic [CNT_W-1:0]  dirty_cnt_q;
	logic [CNT_W-1:0]  clean_low_q;
	logic [CNT_W-1:0]  dirty_low_q;
	logic [CNT_W-1:0]  pool_q;
	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  cur_low;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  dflt;
	logic              full;
	logic              wr_en;
	logic [SLOT_W:0]   wr_addr;
	logic [SLOT_W:0]   rd_addr;
	logic              orig_s1;
	logic [SLOT_W-1:0] dflt_s1;
	logic [SLOT_W-1:0] ram_rd;

	// Select the addressed stack
	assign cur_cnt = (req.sel == STK_DIRTY) ? dirty_cnt_q : clean_cnt_q;
	assign cur_low = (req.sel == STK_DIRTY) ? dirty_low_q : clean_low_q;
	assign cnt_m1  = cur_cnt - CNT_W'(1);
	assign full    = (cur_cnt == CNT_W'(NUM_SLOTS));
	assign wr_en   = req.push && !full;
	assign wr_addr = {req.sel, cur_cnt[SLOT_W-1:0]};
	assign rd_addr = {req.sel, cnt_m1[SLOT_W-1:0]};
	// Restart layout puts slot n-1-i at position i
	assign dflt    = pool_q - cur_cnt;

	gtsa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(2 * NUM_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(req.slot),
		.rd_en  (req.pop),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	// Counts and low-water marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clean_cnt_q <= '0;
			clean_low_q <= '0;
			dirty_cnt_q <= CNT_W'(NUM_SLOTS);
			dirty_low_q <= CNT_W'(NUM_SLOTS);
			pool_q      <= CNT_W'(NUM_SLOTS);
		end else if (cfg.restart) begin
			pool_q <= cfg.slots;
			if (cfg.dirty) begin
				clean_cnt_q <= '0;
				clean_low_q <= '0;
				dirty_cnt_q <= cfg.slots;
				dirty_low_q <= cfg.slots;
			end else begin
				clean_cnt_q <= cfg.slots;
				clean_low_q <= cfg.slots;
				dirty_cnt_q <= '0;
				dirty_low_q <= '0;
			end
		end else begin
			if (req.pop) begin
				if (req.sel == STK_DIRTY) begin
					dirty_cnt_q <= cnt_m1;
					if (cnt_m1 < dirty_low_q) begin
						dirty_low_q <= cnt_m1;
					end
				end else begin
					clean_cnt_q <= cnt_m1;
					if (cnt_m1 < clean_low_q) begin
						clean_low_q <= cnt_m1;
					end
				end
			end
			if (wr_en) begin
				if (req.sel == STK_DIRTY) begin
					dirty_cnt_q <= cur_cnt + CNT_W'(1);
				end else begin
					clean_cnt_q <= cur_cnt + CNT_W'(1);
				end
			end
			// Drop the whole dirty stack
			if (req.clear_dirty) begin
				dirty_cnt_q <= '0;
				dirty_low_q <= '0;
			end
		end
	end

	// Track whether the popped entry still holds its restart value
	always_ff @(posedge clk) begin
		if (req.pop) begin
			orig_s1 <= (cnt_m1 < cur_low);
			dflt_s1 <= dflt[SLOT_W-1:0];
		end
	end

	assign rd_slot          = orig_s1 ? dflt_s1 : ram_rd;
	assign stat.clean_count = clean_cnt_q;
	assign stat.dirty_count = dirty_cnt_q;

endmodule

`default_nettype wire

>>> rtl/gtsa_gen_store.sv
// Per-slot 32-bit generation tags in one RAM, with a valid bit per slot
// so that a pool restart clears all tags at once. Depends on gtsa_pkg, gtsa_ram.
`default_nettype none

module gtsa_gen_store (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     restart,
	input  wire gtsa_pkg::gen_req_t       req,
	output logic [gtsa_pkg::GEN_W-1:0]    rd_gen
);

	import gtsa_pkg::*;

	logic [NUM_SLOTS-1:0] valid_q;
	logic                 valid_s1;
	logic [GEN_W-1:0]     ram_rd;

	gtsa_ram #(
		.WIDTH(GEN_W),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (req.wr),
		.wr_addr(req.wr_addr),
		.wr_data(req.wr_data),
		.rd_en  (req.rd),
		.rd_addr(req.rd_addr),
		.rd_data(ram_rd)
	);

	// Mark written slots; restart drops every tag back to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (restart) begin
			valid_q <= '0;
		end else if (req.wr) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Sample the valid bit alongside the RAM read
	always_ff @(posedge clk) begin
		if (req.rd) begin
			valid_s1 <= valid_q[req.rd_addr];
		end
	end

	assign rd_gen = valid_s1 ? ram_rd : '0;

endmodule

`default_nettype wire

>>> tb/tb_generation_tagged_slot_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for generation_tagged_slot_allocator: directed and random
// acquire, release and flush transactions, checked in order against a behavioral pool.
// Depends on gtsa_pkg and the allocator RTL.

module tb_generation_tagged_slot_allocator;
	import gtsa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 7;
	localparam int PHASE_CMDS     = 30;

	// Where a release takes its slot and generation from when presented
	typedef enum logic [1:0] {
		GEN_AS_GIVEN = 2'd0,
		GEN_CURRENT  = 2'd1,
		GEN_HELD     = 2'd2
	} gen_src_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		gen_src_t          src;
	} pool_cmd_t;

	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		logic [SLOT_W-1:0] start;
		logic [CNT_W-1:0]  count;
		logic              last;
	} grant_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        command = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [GEN_W-1:0]  generation = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              granted;
	logic [SLOT_W-1:0] out_slot;
	logic [GEN_W-1:0]  out_generation;
	logic [SLOT_W-1:0] run_base;
	logic [CNT_W-1:0]  run_length;
	logic              last;

	generation_tagged_slot_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.slot_index    (slot_index),
		.generation    (generation),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted       (granted),
		.out_slot      (out_slot),
		.out_generation(out_generation),
		.run_base      (run_base),
		.run_length    (run_length),
		.last          (last)
	);

	// Behavioral pool state
	logic [CFG_W-1:0]  mirror_slots = CFG_W'(NUM_SLOTS);
	logic              mirror_dirty = 1'b1;
	int                pool_n;
	logic [SLOT_W-1:0] clean_stk [NUM_SLOTS];
	int                clean_depth;
	logic [SLOT_W-1:0] dirty_stk [NUM_SLOTS];
	int                dirty_depth;
	bit                dirty_mark [NUM_SLOTS];
	logic [GEN_W-1:0]  slot_gen [NUM_SLOTS];
	logic [SLOT_W-1:0] held_slots [$];

	pool_cmd_t pending_cmds [$];
	grant_t    awaited_grants [$];
	int        error_count = 0;
	int        accepted_cmds = 0;
	int        idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic grant_t make_grant(logic g, logic [SLOT_W-1:0] s, logic [GEN_W-1:0] gv,
			logic [SLOT_W-1:0] st, logic [CNT_W-1:0] c, logic l);
		grant_t r;
		r.granted = g;
		r.slot    = s;
		r.gen     = gv;
		r.start   = st;
		r.count   = c;
		r.last    = l;
		return r;
	endfunction

	function automatic string show_grant(grant_t r);
		return $sformatf("granted=%0d slot=%0d gen=%08h start=%0d count=%0d last=%0d",
			r.granted, r.slot, r.gen, r.start, r.count, r.last);
	endfunction

	// Append one expected result
	function automatic void expect_grant(grant_t r);
		awaited_grants.insert(awaited_grants.size(), r);
	endfunction

	// Drop the push when the stack is full
	function automatic void push_clean(int s);
		if (clean_depth < NUM_SLOTS) begin
			clean_stk[clean_depth] = SLOT_W'(s);
			clean_depth++;
		end
	endfunction

	function automatic void push_dirty(int s);
		if (dirty_depth < NUM_SLOTS) begin
			dirty_stk[dirty_depth] = SLOT_W'(s);
			dirty_depth++;
		end
	endfunction

	// Rebuild the pool from the mirrored registers, slot 0 on top
	function automatic void restart_pool();
		if (mirror_slots == 0)
			pool_n = 1;
		else if (mirror_slots > NUM_SLOTS)
			pool_n = NUM_SLOTS;
		else
			pool_n = int'(mirror_slots);
		clean_depth = 0;
		dirty_depth = 0;
		held_slots.delete();
		for (int s = 0; s < NUM_SLOTS; s++) begin
			dirty_mark[s] = 1'b0;
			slot_gen[s]   = '0;
		end
		for (int s = pool_n - 1; s >= 0; s--) begin
			if (mirror_dirty) begin
				dirty_mark[s] = 1'b1;
				push_dirty(s);
			end else begin
				push_clean(s);
			end
		end
	endfunction

	// Advance the pool by one accepted transaction and queue the results it causes
	function automatic void apply_pool_cmd(cmd_t c, logic [SLOT_W-1:0] idx, logic [GEN_W-1:0] g);
		int               s;
		bit               got;
		int               runs;
		int               start;
		int               count;
		logic [SLOT_W-1:0] run_start [MAX_RUNS];
		logic [CNT_W-1:0]  run_len [MAX_RUNS];
		got = 1'b0;
		s = 0;
		case (c)
			CMD_ACQUIRE: begin
				if (clean_depth > 0) begin
					clean_depth--;
					s = int'(clean_stk[clean_depth]);
					got = 1'b1;
				end else if (dirty_depth > 0) begin
					dirty_depth--;
					s = int'(dirty_stk[dirty_depth]);
					got = 1'b1;
				end
				if (!got) begin
					expect_grant(make_grant(1'b0, '0, '0, '0, '0, 1'b1));
				end else begin
					dirty_mark[s] = 1'b0;
					slot_gen[s] = slot_gen[s] + 1'b1;
					held_slots.insert(held_slots.size(), SLOT_W'(s));
					expect_grant(make_grant(1'b1, SLOT_W'(s), slot_gen[s], '0, '0, 1'b1));
				end
			end
			CMD_RELEASE: begin
				if (int'(idx) >= pool_n || slot_gen[idx] != g) begin
					expect_grant(make_grant(1'b0, '0, '0, '0, '0, 1'b1));
				end else begin
					slot_gen[idx] = slot_gen[idx] + 1'b1;
					if (mirror_dirty) begin
						// A slot already marked dirty is not pushed twice
						if (!dirty_mark[idx]) begin
							dirty_mark[idx] = 1'b1;
							push_dirty(int'(idx));
						end
					end else begin
						push_clean(int'(idx));
					end
					expect_grant(make_grant(1'b1, '0, '0, '0, '0, 1'b1));
				end
			end
			CMD_FLUSH: begin
				runs = 0;
				start = 0;
				count = 0;
				// Walk the marks upward, coalescing consecutive slots into runs
				for (s = 0; s < NUM_SLOTS; s++) begin
					if (!dirty_mark[s])
						continue;
					if (count > 0 && s == start + count && count < RUN_LIMIT) begin
						count++;
					end else begin
						if (count > 0) begin
							run_start[runs] = SLOT_W'(start);
							run_len[runs] = CNT_W'(count);
							runs++;
							count = 0;
						end
						if (runs >= MAX_RUNS)
							break;
						start = s;
						count = 1;
					end
					dirty_mark[s] = 1'b0;
					push_clean(s);
				end
				if (count > 0) begin
					run_start[runs] = SLOT_W'(start);
					run_len[runs] = CNT_W'(count);
					runs++;
				end
				// Leftover dirty slots go back with the lowest on top
				dirty_depth = 0;
				for (s = NUM_SLOTS - 1; s >= 0; s--) begin
					if (dirty_mark[s])
						push_dirty(s);
				end
				if (runs == 0) begin
					expect_grant(make_grant(1'b1, '0, '0, '0, '0, 1'b1));
				end else begin
					for (int k = 0; k < runs; k++)
						expect_grant(make_grant(1'b1, '0, '0, run_start[k], run_len[k],
							k == runs - 1));
				end
			end
			default: begin
				expect_grant(make_grant(1'b0, '0, '0, '0, '0, 1'b1));
			end
		endcase
	endfunction

	// Idle at random, except in a stretch of back-to-back traffic
	function automatic bit take_break();
		if (accepted_cmds >= 110 && accepted_cmds < 170)
			return 1'b0;
		return $urandom_range(99) < 32;
	endfunction

	function automatic void queue_cmd(cmd_t c, logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g,
			gen_src_t src);
		pool_cmd_t p;
		p.cmd  = c;
		p.slot = s;
		p.gen  = g;
		p.src  = src;
		pending_cmds.insert(pending_cmds.size(), p);
	endfunction

	// Wait until every transaction has drained, then let the block go quiet
	task automatic settle();
		while (pending_cmds.size() > 0 || awaited_grants.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (r == REG_SLOTS_IN_USE)
			mirror_slots = data;
		else
			mirror_dirty = data[0];
		restart_pool();
	endtask

	// Mostly acquire/release traffic on live handles, with flushes and noise
	task automatic queue_random_mix(int num);
		int                r;
		int                top;
		logic [SLOT_W-1:0] s;
		logic [GEN_W-1:0]  g;
		top = (pool_n < NUM_SLOTS) ? pool_n : NUM_SLOTS - 1;
		for (int k = 0; k < num; k++) begin
			r = $urandom_range(99);
			s = SLOT_W'($urandom);
			g = $urandom;
			if (r < 34)
				queue_cmd(CMD_ACQUIRE, s, g, GEN_AS_GIVEN);
			else if (r < 58)
				queue_cmd(CMD_RELEASE, s, '0, GEN_HELD);
			else if (r < 63)
				queue_cmd(CMD_RELEASE, s, $urandom_range(1) ? '1 : (g | 1), GEN_HELD);
			else if (r < 71)
				queue_cmd(CMD_RELEASE, SLOT_W'($urandom_range(top)), '0, GEN_CURRENT);
			else if (r < 78)
				queue_cmd(CMD_RELEASE, s, $urandom_range(1) ? GEN_W'($urandom_range(3)) : g,
					GEN_AS_GIVEN);
			else if (r < 95)
				queue_cmd(CMD_FLUSH, s, g, GEN_AS_GIVEN);
			else
				queue_cmd(CMD_NONE, s, g, GEN_AS_GIVEN);
		end
	endtask

	// Stimulus sequence
	initial begin : stimulus
		logic [CFG_W-1:0] n_cfg;
		logic             d_cfg;
		restart_pool();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Reset pool: 64 dirty slots
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);              // one full-length run
		queue_cmd(CMD_FLUSH, '1, '1, GEN_AS_GIVEN);              // nothing dirty
		queue_cmd(CMD_ACQUIRE, '1, '1, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd63, 32'd1, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd63, 32'd2, GEN_AS_GIVEN);      // already dirty
		queue_cmd(CMD_RELEASE, 6'd63, 32'hFFFF_FFFF, GEN_AS_GIVEN); // wrong generation
		queue_cmd(CMD_RELEASE, 6'd0, 32'd0, GEN_AS_GIVEN);       // free slot, current tag
		queue_cmd(CMD_NONE, 6'h2A, 32'h5555_5555, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, 6'h15, 32'hAAAA_AAAA, GEN_AS_GIVEN);
		settle();

		// Single clean slot: empty pool and out-of-range release
		write_reg(REG_DIRTY_ON_RELEASE, 7'd0);
		write_reg(REG_SLOTS_IN_USE, 7'd1);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd1, 32'd0, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd0, 32'd1, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd0, 32'd3, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd0, 32'd4, GEN_AS_GIVEN);       // pushed onto clean again
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);
		settle();

		// Zero slot count, dirty mode with upper data bits set
		write_reg(REG_SLOTS_IN_USE, 7'd0);
		write_reg(REG_DIRTY_ON_RELEASE, 7'h7F);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);            // taken from the dirty stack
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_RELEASE, 6'd0, 32'd1, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		queue_cmd(CMD_ACQUIRE, '0, '0, GEN_AS_GIVEN);
		settle();

		// Oversized slot count; scatter even slots to reach the most runs
		write_reg(REG_DIRTY_ON_RELEASE, 7'd1);
		write_reg(REG_SLOTS_IN_USE, 7'h7F);
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);
		for (int k = 0; k < NUM_SLOTS; k += 2)
			queue_cmd(CMD_RELEASE, SLOT_W'(k), '0, GEN_CURRENT);
		queue_cmd(CMD_FLUSH, '0, '0, GEN_AS_GIVEN);
		queue_random_mix(8);
		settle();

		// Random traffic over several pool settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin n_cfg = 7'd64; d_cfg = 1'b1; end
				1: begin n_cfg = 7'd64; d_cfg = 1'b0; end
				2: begin n_cfg = CFG_W'($urandom_range(63, 2)); d_cfg = 1'b1; end
				3: begin n_cfg = 7'd1; d_cfg = 1'b0; end
				4: begin n_cfg = 7'd2; d_cfg = 1'b1; end
				5: begin n_cfg = CFG_W'($urandom_range(63, 2)); d_cfg = 1'b0; end
				default: begin n_cfg = CFG_W'($urandom_range(127, 65)); d_cfg = 1'b1; end
			endcase
			if ($urandom_range(1)) begin
				write_reg(REG_SLOTS_IN_USE, n_cfg);
				write_reg(REG_DIRTY_ON_RELEASE, {(CFG_W-1)'($urandom_range(63)), d_cfg});
			end else begin
				write_reg(REG_DIRTY_ON_RELEASE, {(CFG_W-1)'($urandom_range(63)), d_cfg});
				write_reg(REG_SLOTS_IN_USE, n_cfg);
			end
			queue_random_mix(PHASE_CMDS);
			settle();
		end

		if (error_count == 0 && awaited_grants.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Command driver: predict on acceptance, then present the next transaction
	always @(posedge clk) begin : cmd_driver
		pool_cmd_t         nxt;
		logic [SLOT_W-1:0] s;
		int                k;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_pool_cmd(cmd_t'(command), slot_index, generation);
				void'(pending_cmds.pop_front());
				accepted_cmds++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 && !take_break()) begin
					nxt = pending_cmds[0];
					s = nxt.slot;
					if (nxt.src == GEN_HELD && held_slots.size() > 0) begin
						k = $urandom_range(held_slots.size() - 1);
						s = held_slots[k];
						held_slots.delete(k);
					end
					command    <= nxt.cmd;
					slot_index <= s;
					// Resolve live tags against the pool as it stands now
					if (nxt.src == GEN_AS_GIVEN)
						generation <= nxt.gen;
					else
						generation <= slot_gen[s] + nxt.gen;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_monitor
		grant_t seen;
		grant_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = make_grant(granted, out_slot, out_generation, run_base, run_length, last);
				if (awaited_grants.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result: %s", show_grant(seen));
				end else begin
					want = awaited_grants.pop_front();
					if (seen !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("result mismatch: expected %s, got %s",
								show_grant(want), show_grant(seen));
					end
				end
			end
			out_stall <= take_break();
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

>>> sim.f
rtl/gtsa_pkg.sv
rtl/gtsa_ram.sv
rtl/gtsa_stack.sv
rtl/gtsa_gen_store.sv
rtl/generation_tagged_slot_allocator.sv
tb/tb_generation_tagged_slot_allocator.sv
